// File: design/bisas_pkg.sv
// shared types and constants for the bitmap indexed sparse store
// no dependencies; imported by every module of the block
package bisas_pkg;

  localparam int KEY_W        = 6;
  localparam int MAP_W        = 64;
  localparam int WORD_W       = 32;
  localparam int CMP_W        = KEY_W + 1;
  localparam int CAPACITY_DEF = 32;

  // opcode values
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // status values
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  axis_key;
    logic [WORD_W-1:0] write_word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              status_code;
    logic              key_present;
  } rsp_t;

endpackage

// File: design/bisas_mem.sv
// packed word memory: one write port, one registered read port
// depends on bisas_pkg for the word width and the default depth
module bisas_mem #(
  parameter int DEPTH = bisas_pkg::CAPACITY_DEF,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bisas_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bisas_pkg::WORD_W-1:0] rdata
);
  import bisas_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/bisas_slot.sv
// slot unit: registered popcount of the presence bits below a key
// depends on bisas_pkg for key and map widths
module bisas_slot (
  input  logic                        clk,
  input  logic [bisas_pkg::MAP_W-1:0] map,
  input  logic [bisas_pkg::KEY_W-1:0] key,
  output logic [bisas_pkg::KEY_W-1:0] slot
);
  import bisas_pkg::*;

  localparam int BYTES = MAP_W / 8;

  logic [MAP_W-1:0] below;
  logic [3:0]       byte_cnt [BYTES];
  logic [KEY_W-1:0] total;

  // mask off the key and everything above it
  assign below = map & ((MAP_W'(1) << key) - MAP_W'(1));

  // per-byte counts
  always_comb begin
    for (int b = 0; b < BYTES; b++) begin
      byte_cnt[b] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(below[b*8+i]);
      end
    end
  end

  // sum of byte counts; at most 63 since the key bit is masked
  always_comb begin
    total = '0;
    for (int b = 0; b < BYTES; b++) begin
      total = total + KEY_W'(byte_cnt[b]);
    end
  end

  always_ff @(posedge clk) begin
    slot <= total;
  end

endmodule

// File: design/bitmap_indexed_sparse_axis_store.sv
// top level of the bitmap indexed sparse store: control, presence map, result register
// depends on bisas_pkg, bisas_slot and bisas_mem
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------
//   request | req_valid | req_stall | req (opcode, key, word)
//   result  | rsp_valid | rsp_stall | rsp (word, status, present)
//
// an absent read, an overwrite, a zero write to an absent key or a refused write
// passes through S_SLOT, S_DECIDE and S_RESULT, a present read also through S_RDWAIT;
// an insertion adds one S_SHIFT per packed entry above the new slot, since the memory
// moves one word per cycle, and then S_INSERT before S_RESULT.
// one item is in flight at a time; the next request can transfer as soon as the
// result appears. a finished result waits in the output register while the next
// request is taken. rst is synchronous and empties the map; the memory needs no
// clearing since the map decides which slots are read.
module bitmap_indexed_sparse_axis_store #(
  parameter int CAPACITY = bisas_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  bisas_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bisas_pkg::rsp_t rsp
);
  import bisas_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SLOT   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_RDWAIT = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_INSERT = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [MAP_W-1:0]  map;
  logic [CW-1:0]     count;
  req_t              cur;
  logic              present;
  logic [AW-1:0]     ptr;
  rsp_t              pend;
  logic [KEY_W-1:0]  slot;
  logic [CMP_W-1:0]  slot_ext, cnt_ext, ptr_ext;
  logic              word_zero;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  assign req_stall = (state != S_IDLE);
  assign slot_ext  = CMP_W'(slot);
  assign cnt_ext   = CMP_W'(count);
  assign ptr_ext   = CMP_W'(ptr);
  // +0 and -0 differ only in the sign bit
  assign word_zero = (cur.write_word[WORD_W-2:0] == '0);

  bisas_slot u_slot (
    .clk  (clk),
    .map  (map),
    .key  (cur.axis_key),
    .slot (slot)
  );

  bisas_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state and memory port control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = slot[AW-1:0];
    mem_wdata  = cur.write_word;
    mem_re     = 1'b0;
    mem_raddr  = slot[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SLOT;
      end
      S_SLOT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (cur.opcode == OP_READ) begin
          if (present) begin
            mem_re     = 1'b1;
            state_next = S_RDWAIT;
          end else begin
            state_next = S_RESULT;
          end
        end else if (present) begin
          mem_we     = 1'b1;
          state_next = S_RESULT;
        end else if (word_zero || cnt_ext >= CAP_EXT) begin
          state_next = S_RESULT;
        end else if (cnt_ext > slot_ext) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(cnt_ext - CMP_W'(1));
          state_next = S_SHIFT;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_RDWAIT: begin
        state_next = S_RESULT;
      end
      S_SHIFT: begin
        // move the word read last cycle up one slot, fetch the next one down
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        if (ptr_ext > slot_ext + CMP_W'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_ext - CMP_W'(2));
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        mem_we     = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      map       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INSERT) begin
        map[cur.axis_key] <= 1'b1;
        count             <= count + CW'(1);
      end
      if (state == S_RESULT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur     <= req;
          present <= map[req.axis_key];
          pend    <= '0;
        end
      end
      S_DECIDE: begin
        ptr <= AW'(cnt_ext);
        if (cur.opcode == OP_WRITE) begin
          pend.key_present <= present;
          if (!present && !word_zero && cnt_ext >= CAP_EXT) begin
            pend.status_code <= ST_FULL;
          end
        end else begin
          pend.key_present <= present;
        end
      end
      S_RDWAIT: begin
        pend.read_word <= mem_rdata;
      end
      S_SHIFT: begin
        ptr <= AW'(ptr_ext - CMP_W'(1));
      end
      S_INSERT: begin
        pend.key_present <= 1'b1;
        pend.status_code <= ST_OK;
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) rsp <= pend;
      end
      default: begin
      end
    endcase
  end

  // the count always tracks the number of present keys
  a_count_map: assert property (@(posedge clk) disable iff (rst)
    $countones(map) == 32'(count))
    else $error("entry count differs from presence map");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= CAP_EXT)
    else $error("entry count above capacity");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (ptr_ext > slot_ext))
    else $error("shift pointer at or below insert slot");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> (cnt_ext < CAP_EXT && !present))
    else $error("insert into full store or over present key");

endmodule

// File: verif/bitmap_indexed_sparse_axis_store_test.sv
// self-checking testbench for bitmap_indexed_sparse_axis_store: directed and random reads/writes
// depends on bisas_pkg and the block's RTL; keeps its own map/packed-word model of the store
// driver and stall generator run at the falling edge, checks run at the rising edge
module bitmap_indexed_sparse_axis_store_test;
  import bisas_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int LIMIT      = 400000;
  localparam int QUIET_TAIL = 100;
  localparam int RAND_ITEMS = 700;

  typedef struct packed {
    logic drain_first;
    req_t item;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // stimulus and expectations
  pending_t stim_queue[$];
  rsp_t expected_rsps[$];
  pending_t head_item;

  // model of the store as seen at accepted transfers
  logic [MAP_W-1:0]  store_map = '0;
  logic [WORD_W-1:0] store_words [0:CAP-1];
  int store_count = 0;

  // shadow map used only to steer the generator
  logic [MAP_W-1:0] gen_map = '0;
  int gen_count = 0;

  int err_count = 0;
  int cycle_count = 0;
  int rst_left = 6;
  int send_gap = 0;
  int stall_left = 0;
  bit req_taken = 1'b0;

  bitmap_indexed_sparse_axis_store #(.CAPACITY(CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // number of present keys strictly below the given key
  function automatic int ones_below(logic [MAP_W-1:0] map, logic [KEY_W-1:0] key);
    int n;
    n = 0;
    for (int b = 0; b < MAP_W; b++) begin
      if (b < key && map[b]) n++;
    end
    return n;
  endfunction

  // apply one accepted request to the model and return the result it produces
  function automatic rsp_t apply_access(req_t r);
    rsp_t o;
    logic [MAP_W-1:0] key_bit;
    logic hit;
    int slot;
    o = '0;
    o.status_code = ST_OK;
    key_bit = {{(MAP_W-1){1'b0}}, 1'b1} << r.axis_key;
    hit = |(store_map & key_bit);
    slot = ones_below(store_map, r.axis_key);
    if (r.opcode == OP_WRITE) begin
      if (hit) begin
        store_words[slot] = r.write_word;
      end else if (r.write_word[WORD_W-2:0] != '0) begin
        // nonzero word to a new key: refuse when full, else shift up and insert
        if (store_count >= CAP) begin
          o.status_code = ST_FULL;
        end else begin
          for (int i = store_count; i > slot; i--) store_words[i] = store_words[i-1];
          store_words[slot] = r.write_word;
          store_map = store_map | key_bit;
          store_count++;
          hit = 1'b1;
        end
      end
    end else if (hit) begin
      o.read_word = store_words[slot];
    end
    o.key_present = hit;
    return o;
  endfunction

  // queue one request and track which keys will be present
  task automatic push_req(logic op, logic [KEY_W-1:0] key, logic [WORD_W-1:0] word,
                          logic drain);
    pending_t p;
    p.drain_first = drain;
    p.item.opcode = op;
    p.item.axis_key = key;
    p.item.write_word = word;
    stim_queue.push_back(p);
    if (op == OP_WRITE && !gen_map[key] && word[WORD_W-2:0] != '0 && gen_count < CAP) begin
      gen_map[key] = 1'b1;
      gen_count++;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_present_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    while (!gen_map[k]) k = KEY_W'($urandom);
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = 32'hFFFF_FFFF;
      1: w = 32'h0000_0001;
      2: w = 32'h8000_0001;
      3: w = 32'h7FFF_FFFF;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] signed_zero();
    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
  endfunction

  // stimulus build, end-of-run wait and verdict
  initial begin
    int r;
    logic [KEY_W-1:0] k;
    logic drain;

    // directed: absent reads, signed zeros, edge keys, inserts at both ends, overwrites
    push_req(OP_READ,  6'd0,  32'h0000_0000, 1'b0);
    push_req(OP_READ,  6'd63, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_WRITE, 6'd5,  32'h0000_0000, 1'b0);
    push_req(OP_WRITE, 6'd5,  32'h8000_0000, 1'b0);
    push_req(OP_READ,  6'd5,  32'h0000_0000, 1'b0);
    push_req(OP_WRITE, 6'd63, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_WRITE, 6'd0,  32'h0000_0001, 1'b0);
    push_req(OP_WRITE, 6'd31, 32'h8000_0001, 1'b0);
    push_req(OP_WRITE, 6'd32, 32'hA5A5_A5A5, 1'b0);
    push_req(OP_READ,  6'd0,  32'h0000_0000, 1'b0);
    push_req(OP_READ,  6'd31, 32'h0000_0000, 1'b0);
    push_req(OP_READ,  6'd32, 32'h0000_0000, 1'b0);
    push_req(OP_READ,  6'd63, 32'h0000_0000, 1'b0);
    push_req(OP_WRITE, 6'd31, 32'h7FFF_FFFF, 1'b0);
    push_req(OP_WRITE, 6'd0,  32'h0000_0000, 1'b0);
    push_req(OP_READ,  6'd0,  32'h0000_0000, 1'b0);
    push_req(OP_WRITE, 6'd63, 32'h8000_0000, 1'b0);
    push_req(OP_READ,  6'd63, 32'h0000_0000, 1'b0);
    push_req(OP_WRITE, 6'd62, 32'h5A5A_5A5A, 1'b0);
    push_req(OP_READ,  6'd31, 32'h0000_0000, 1'b0);
    push_req(OP_READ,  6'd62, 32'h0000_0000, 1'b0);

    // random: mostly reads and overwrites, inserts fill the store gradually
    for (int i = 0; i < RAND_ITEMS; i++) begin
      drain = (i % 150 == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_req(OP_READ, KEY_W'($urandom), $urandom, drain);
      end else if (r < 55) begin
        k = (gen_count != 0) ? pick_present_key() : KEY_W'($urandom);
        push_req(OP_READ, k, $urandom, drain);
      end else if (r < 70) begin
        k = (gen_count != 0) ? pick_present_key() : KEY_W'($urandom);
        push_req(OP_WRITE, k, ($urandom_range(0, 5) == 0) ? signed_zero() : rand_word(), drain);
      end else if (r < 78) begin
        push_req(OP_WRITE, KEY_W'($urandom), signed_zero(), drain);
      end else begin
        // late in the run always aim at any key so the store surely fills up
        if (i >= 400 || gen_count == 0 || $urandom_range(0, 3) == 0) k = KEY_W'($urandom);
        else k = pick_present_key();
        push_req(OP_WRITE, k, rand_word(), drain);
      end
    end

    // wait for the last transfer, then for every result, then for the block to settle
    while (stim_queue.size() != 0 || req_valid) @(negedge clk);
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (CAP + 10) @(negedge clk);
    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("bitmap_indexed_sparse_axis_store_test: PASS");
    end else begin
      $display("bitmap_indexed_sparse_axis_store_test: FAIL");
    end
    $finish;
  end

  // reset release, request driver and result stall generator
  always @(negedge clk) begin
    if (rst_left != 0) begin
      rst_left <= rst_left - 1;
      if (rst_left == 1) rst <= 1'b0;
    end else begin
      // request side: move on only after the current item transferred
      if (!req_valid || req_taken) begin
        req_taken = 1'b0;
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (stim_queue.size() == 0) begin
          req_valid <= 1'b0;
        end else if (stim_queue[0].drain_first && expected_rsps.size() != 0) begin
          req_valid <= 1'b0;
        end else if (stim_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 8);
          req_valid <= 1'b0;
        end else begin
          head_item = stim_queue.pop_front();
          req <= head_item.item;
          req_valid <= 1'b1;
        end
      end
      // result side: stall bursts, none in the last part of the run
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (stim_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 8);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // transfer monitor: predict on request transfers, compare on result transfers
  always @(posedge clk) begin
    rsp_t want;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("bitmap_indexed_sparse_axis_store_test: FAIL");
      $finish;
    end else if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(apply_access(req));
        req_taken = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transfer: read_word %h status_code %b key_present %b",
                 rsp.read_word, rsp.status_code, rsp.key_present);
          err_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.read_word !== want.read_word) begin
            $error("read_word: expected %h, got %h", want.read_word, rsp.read_word);
            err_count++;
          end
          if (rsp.status_code !== want.status_code) begin
            $error("status_code: expected %b, got %b", want.status_code, rsp.status_code);
            err_count++;
          end
          if (rsp.key_present !== want.key_present) begin
            $error("key_present: expected %b, got %b", want.key_present, rsp.key_present);
            err_count++;
          end
        end
      end
    end
  end

endmodule
